### rtl/lfbs_pkg.sv
// ----------------------------------------------------------------------------
// lfbs_pkg
// Shared types, constants and helper functions for the LIN frame bit
// serialiser: command kinds, the loaded frame descriptor, parity and clamping.
// ----------------------------------------------------------------------------
`default_nettype none

package lfbs_pkg;

  // Command kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_BREAK    = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_IDENT    = 2'd2,
    KIND_CHECKSUM = 2'd3
  } kind_e;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ShiftW = ByteW + 1;  // start bit plus eight data bits
  localparam int unsigned CountW = 5;          // holds the longest break length

  localparam logic [CountW-1:0] BreakMin = CountW'(13);
  localparam logic [CountW-1:0] BreakMax = CountW'(26);
  localparam logic [CountW-1:0] ByteCnt  = CountW'(ShiftW);
  localparam logic [ByteW-1:0]  IdMask   = 8'h3F;
  localparam logic [ByteW-1:0]  ByteMask = 8'hFF;

  // Frame handed from the encoder to the shifter.
  // bits: periods sent before the final one, LSB first (zeros fill in).
  // cnt:  number of periods before the final recessive period.
  typedef struct packed {
    logic [ShiftW-1:0] bits;
    logic [CountW-1:0] cnt;
  } frame_t;

  // Build the protected identifier: P0 in bit 6, inverted P1 in bit 7
  function automatic logic [ByteW-1:0] protect_id(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] id;
    logic             p0;
    logic             p1;
    id = v & IdMask;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id[5:0]};
  endfunction

  // Hold the break length inside its legal range
  function automatic logic [CountW-1:0] clamp_break(input logic [CountW-1:0] b);
    logic [CountW-1:0] r;
    r = b;
    if (b < BreakMin) r = BreakMin;
    if (b > BreakMax) r = BreakMax;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/lin_frame_bit_serializer_core.sv
// ----------------------------------------------------------------------------
// lin_frame_bit_serializer_core
// LIN master frame transmitter: break, data, protected identifier and
// checksum commands in, one TX line level per bit period out.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis group: tuser holds the kind, tdata the byte.
//   Line levels leave on the m_axis group, one item per bit period; tlast
//   marks the final period of each command.
//   A data, identifier or checksum command gives ten items; a break gives
//   break_bits (held to 13..26) dominant items plus one recessive delimiter.
//   The cfg channel writes break_bits; it is always ready.
// Flow:
//   A command is registered in the input register, encoded and loaded into
//   the shifter, which presents its first item once the shifter is free.
//   The shifter sends one item per cycle while m_axis_tready is high; the
//   next command waits in the input register and follows without a gap.
// Reset: checksum cleared, break_bits set to 13, both channels empty.
// Stall: with m_axis_tready low the current item holds, and once the input
//   register is full s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module lin_frame_bit_serializer_core
  import lfbs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration write
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CountW-1:0] cfg_data_i,      // [4:0] break_bits
  // command input
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [7:0]        s_axis_tdata_i,  // [7:0] value
  input  wire logic [1:0]        s_axis_tuser_i,  // [1:0] kind
  // line level output
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [7:0]             m_axis_tdata_o,  // [0] tx_level, [7:1] zero
  output logic                   m_axis_tlast_o
);

  logic              in_valid_q;
  kind_e             kind_q;
  logic [ByteW-1:0]  value_q;
  logic [CountW-1:0] break_bits_q;
  logic              take;
  logic              level;
  frame_t            frame;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = ~in_valid_q | take;
  assign m_axis_tdata_o  = {7'd0, level};

  // Hold the break length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      break_bits_q <= BreakMin;
    end else if (cfg_valid_i) begin
      break_bits_q <= cfg_data_i;
    end
  end

  // Input register: fill on accept, drop when the shifter takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      kind_q  <= kind_e'(s_axis_tuser_i);
      value_q <= s_axis_tdata_i;
    end
  end

  lfbs_encode u_encode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_q),
    .value_i      (value_q),
    .break_bits_i (break_bits_q),
    .load_i       (take),
    .frame_o      (frame)
  );

  lfbs_shifter u_shifter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (frame),
    .frame_valid_i (in_valid_q),
    .frame_take_o  (take),
    .out_valid_o   (m_axis_tvalid_o),
    .out_level_o   (level),
    .out_last_o    (m_axis_tlast_o),
    .out_ready_i   (m_axis_tready_i)
  );

endmodule

`default_nettype wire

### rtl/lfbs_encode.sv
// ----------------------------------------------------------------------------
// lfbs_encode
// Turns a registered command into a frame descriptor and keeps the running
// LIN classic checksum, updated when the frame is handed to the shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbs_encode
  import lfbs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kind_e             kind_i,
  input  wire logic [ByteW-1:0]  value_i,
  input  wire logic [CountW-1:0] break_bits_i,
  input  wire logic              load_i,
  output frame_t                 frame_o
);

  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW:0]   add_wide;
  logic [ByteW-1:0] add_wrap;
  logic [ByteW-1:0] byte_sel;

  // Add with end-around carry
  assign add_wide = {1'b0, sum_q} + {1'b0, value_i};
  assign add_wrap = add_wide[ByteW-1:0] + {{(ByteW-1){1'b0}}, add_wide[ByteW]};

  // Pick the byte and build the frame
  always_comb begin
    byte_sel = value_i;
    sum_d    = sum_q;
    case (kind_i)
      KIND_BREAK: begin
        byte_sel = '0;
        sum_d    = '0;
      end
      KIND_DATA: begin
        byte_sel = value_i;
        sum_d    = add_wrap;
      end
      KIND_IDENT: begin
        byte_sel = protect_id(value_i);
      end
      KIND_CHECKSUM: begin
        byte_sel = ~sum_q & ByteMask;
      end
      default: begin
        byte_sel = value_i;
      end
    endcase

    if (kind_i == KIND_BREAK) begin
      frame_o.bits = '0;
      frame_o.cnt  = clamp_break(break_bits_i);
    end else begin
      frame_o.bits = {byte_sel, 1'b0};
      frame_o.cnt  = ByteCnt;
    end
  end

  // Hold the checksum; advance it only when the frame is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (load_i) begin
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

### rtl/lfbs_shifter.sv
// ----------------------------------------------------------------------------
// lfbs_shifter
// Result register and bit shifter: presents one line level per bit period
// and flags the final period of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbs_shifter
  import lfbs_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire frame_t frame_i,
  input  wire logic   frame_valid_i,
  output logic        frame_take_o,
  output logic        out_valid_o,
  output logic        out_level_o,
  output logic        out_last_o,
  input  wire logic   out_ready_i
);

  logic              active_q, active_d;
  logic [ShiftW-1:0] bits_q, bits_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              final_bit;

  assign final_bit    = (cnt_q == '0);
  assign out_valid_o  = active_q;
  assign out_last_o   = final_bit;
  assign out_level_o  = final_bit | bits_q[0];
  assign frame_take_o = frame_valid_i & (~active_q | (out_ready_i & final_bit));

  // Load a new frame, advance on each taken item, or hold
  always_comb begin
    active_d = active_q;
    bits_d   = bits_q;
    cnt_d    = cnt_q;
    if (frame_take_o) begin
      active_d = 1'b1;
      bits_d   = frame_i.bits;
      cnt_d    = frame_i.cnt;
    end else if (active_q && out_ready_i) begin
      if (final_bit) begin
        active_d = 1'b0;
      end else begin
        bits_d = {1'b0, bits_q[ShiftW-1:1]};
        cnt_d  = cnt_q - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    cnt_q  <= cnt_d;
  end

endmodule

`default_nettype wire
